[design/cfdf_pkg.sv]
`default_nettype none
package cfdf_pkg;
  localparam logic [7:0] SYNC_FIRST = 8'hBE;
  localparam logic [7:0] SYNC_SECOND = 8'hBA;
  localparam logic [7:0] TEXT_CODE_RESET = 8'h5D;
  localparam logic [7:0] BINARY_CODE_RESET = 8'h5E;

  localparam logic [1:0] ACT_RECV = 2'd0;
  localparam logic [1:0] ACT_POP_TEXT = 2'd1;
  localparam logic [1:0] ACT_POP_BINARY = 2'd2;

  localparam logic [0:0] CFG_TEXT_CODE = 1'b0;
  localparam logic [0:0] CFG_BINARY_CODE = 1'b1;

  localparam logic [2:0] RES_NONE = 3'd0;
  localparam logic [2:0] RES_TEXT = 3'd1;
  localparam logic [2:0] RES_BINARY = 3'd2;
  localparam logic [2:0] RES_OTHER = 3'd3;
  localparam logic [2:0] RES_BADSUM = 3'd4;
  localparam logic [2:0] RES_OVERLONG = 3'd5;
  localparam logic [2:0] RES_FULL = 3'd6;

  localparam logic [2:0] PH_SYNC0 = 3'd0;
  localparam logic [2:0] PH_SYNC1 = 3'd1;
  localparam logic [2:0] PH_LEN0 = 3'd2;
  localparam logic [2:0] PH_LEN1 = 3'd3;
  localparam logic [2:0] PH_CMD = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_CK0 = 3'd6;
  localparam logic [2:0] PH_CK1 = 3'd7;
endpackage
`default_nettype wire

[design/command_frame_deframer_fifo_core.sv]
// channel | valid    | stall    | fields
// in      | in_valid | in_stall | action, link_byte
// out     | out_valid| out_stall| read_byte, read_valid, frame_result,
//         |          |          | text_level, binary_level, dropped_frames
// One item at a time. A link byte or pop passes through a memory read, then
// a result. The last checksum byte of a good frame copies its payload into
// the target FIFO one byte per cycle through the single frame store read
// port. No clearing pass after reset. in_stall is high while an item is at
// work or its result waits behind out_stall.
`default_nettype none
module command_frame_deframer_fifo_core
  import cfdf_pkg::*;
#(
  parameter int FRAME_BYTES = 512,
  parameter int FIFO_BYTES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  link_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       read_byte,
  output logic             read_valid,
  output logic [2:0]       frame_result,
  output logic [10:0]      text_level,
  output logic [10:0]      binary_level,
  output logic [31:0]      dropped_frames
);
  localparam int FAW = $clog2(FRAME_BYTES);
  localparam int QAW = $clog2(FIFO_BYTES);
  localparam int QLW = QAW + 1;
  localparam logic [16:0] FRAME_MAX = 17'(FRAME_BYTES);
  localparam logic [16:0] FIFO_MAX = 17'(FIFO_BYTES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_COPY = 2'd2;
  localparam logic [1:0] ST_OUT = 2'd3;

  logic [7:0] payload_mem [FRAME_BYTES];
  logic [7:0] text_mem [FIFO_BYTES];
  logic [7:0] binary_mem [FIFO_BYTES];

  logic [1:0] state;
  logic [7:0] text_code, binary_code;
  logic [2:0] phase;
  logic [15:0] frame_length, payload_received, running_sum;
  logic [7:0] check_low, command_code;
  logic too_long;
  logic [QAW-1:0] text_head, binary_head;
  logic [QLW-1:0] text_fill, binary_fill;
  logic [31:0] drop_counter;

  logic [1:0] act;
  logic [7:0] byte_in;
  logic [7:0] text_rd, binary_rd, payload_rd;
  logic copy_text;
  logic [15:0] copy_idx;
  logic copy_rd_valid;
  logic [QAW-1:0] copy_wr_addr;

  logic [7:0] res_byte;
  logic res_valid;
  logic [2:0] res_code;

  assign in_stall = (state != ST_IDLE);
  assign text_level = 11'(text_fill);
  assign binary_level = 11'(binary_fill);
  assign dropped_frames = drop_counter;

  logic [15:0] check_full, sum_plus;
  logic [16:0] room_text, room_binary, length_ext;
  logic fits_text, fits_binary;
  assign check_full = {byte_in, check_low};
  assign sum_plus = running_sum + 16'(byte_in);
  assign length_ext = {1'b0, frame_length};
  assign room_text = FIFO_MAX - 17'(text_fill);
  assign room_binary = FIFO_MAX - 17'(binary_fill);
  assign fits_text = (length_ext <= room_text);
  assign fits_binary = (length_ext <= room_binary);

  // synchronous reads
  always_ff @(posedge clk) begin
    text_rd <= text_mem[text_head];
    binary_rd <= binary_mem[binary_head];
    payload_rd <= payload_mem[copy_idx[FAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid && action == ACT_RECV && phase == PH_PAYLOAD
        && !too_long && payload_received < 16'(FRAME_BYTES))
      payload_mem[payload_received[FAW-1:0]] <= link_byte;
    if (copy_rd_valid && copy_text) text_mem[copy_wr_addr] <= payload_rd;
    if (copy_rd_valid && !copy_text) binary_mem[copy_wr_addr] <= payload_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      text_code <= TEXT_CODE_RESET;
      binary_code <= BINARY_CODE_RESET;
      phase <= PH_SYNC0;
      frame_length <= '0;
      payload_received <= '0;
      running_sum <= '0;
      check_low <= '0;
      command_code <= '0;
      too_long <= 1'b0;
      text_head <= '0;
      binary_head <= '0;
      text_fill <= '0;
      binary_fill <= '0;
      drop_counter <= '0;
      copy_rd_valid <= 1'b0;
      copy_idx <= '0;
      copy_text <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TEXT_CODE: text_code <= cfg_data;
          CFG_BINARY_CODE: binary_code <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            act <= action;
            byte_in <= link_byte;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          res_byte <= '0;
          res_valid <= 1'b0;
          res_code <= RES_NONE;
          state <= ST_OUT;
          out_valid <= 1'b1;
          case (act)
            ACT_POP_TEXT: if (text_fill != '0) begin
              res_byte <= text_rd;
              res_valid <= 1'b1;
              text_head <= text_head + 1'b1;
              text_fill <= text_fill - 1'b1;
            end
            ACT_POP_BINARY: if (binary_fill != '0) begin
              res_byte <= binary_rd;
              res_valid <= 1'b1;
              binary_head <= binary_head + 1'b1;
              binary_fill <= binary_fill - 1'b1;
            end
            ACT_RECV: begin
              case (phase)
                PH_SYNC0: if (byte_in == SYNC_FIRST) begin
                  running_sum <= 16'(byte_in);
                  phase <= PH_SYNC1;
                end
                PH_SYNC1: begin
                  if (byte_in == SYNC_SECOND) begin
                    running_sum <= sum_plus;
                    phase <= PH_LEN0;
                  end else if (byte_in == SYNC_FIRST) running_sum <= 16'(byte_in);
                  else phase <= PH_SYNC0;
                end
                PH_LEN0: begin
                  running_sum <= sum_plus;
                  frame_length <= {8'd0, byte_in};
                  phase <= PH_LEN1;
                end
                PH_LEN1: begin
                  running_sum <= sum_plus;
                  frame_length <= {byte_in, frame_length[7:0]};
                  payload_received <= '0;
                  too_long <= ({1'b0, byte_in, frame_length[7:0]} > FRAME_MAX);
                  phase <= PH_CMD;
                end
                PH_CMD: begin
                  running_sum <= sum_plus;
                  command_code <= byte_in;
                  phase <= (frame_length != '0) ? PH_PAYLOAD : PH_CK0;
                end
                PH_PAYLOAD: begin
                  running_sum <= sum_plus;
                  payload_received <= payload_received + 16'd1;
                  if (payload_received + 16'd1 >= frame_length) phase <= PH_CK0;
                end
                PH_CK0: begin
                  check_low <= byte_in;
                  phase <= PH_CK1;
                end
                default: begin
                  phase <= PH_SYNC0;
                  if (too_long) res_code <= RES_OVERLONG;
                  else if (check_full != running_sum) res_code <= RES_BADSUM;
                  else if (command_code == text_code || command_code == binary_code) begin
                    if ((command_code == text_code) ? fits_text : fits_binary) begin
                      res_code <= (command_code == text_code) ? RES_TEXT : RES_BINARY;
                      copy_text <= (command_code == text_code);
                      copy_idx <= '0;
                      if (frame_length != '0) begin
                        state <= ST_COPY;
                        out_valid <= 1'b0;
                      end
                    end else begin
                      res_code <= RES_FULL;
                      drop_counter <= drop_counter + 32'd1;
                    end
                  end else res_code <= RES_OTHER;
                end
              endcase
            end
            default: ;
          endcase
        end
        ST_COPY: begin
          // advance read index; the write lands in the following cycle, past the byte
          // being written now
          copy_rd_valid <= (copy_idx < frame_length);
          if (copy_idx < frame_length) copy_idx <= copy_idx + 16'd1;
          if (copy_text)
            copy_wr_addr <= QAW'(text_head + QAW'(text_fill) + QAW'(copy_rd_valid));
          else
            copy_wr_addr <= QAW'(binary_head + QAW'(binary_fill) + QAW'(copy_rd_valid));
          if (copy_rd_valid) begin
            if (copy_text) text_fill <= text_fill + 1'b1;
            else binary_fill <= binary_fill + 1'b1;
          end
          if (copy_rd_valid && copy_idx >= frame_length) begin
            copy_rd_valid <= 1'b0;
            state <= ST_OUT;
            out_valid <= 1'b1;
          end
        end
        default: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign read_byte = res_byte;
  assign read_valid = res_valid;
  assign frame_result = res_code;
endmodule
`default_nettype wire
